FILE: rtl/ptcs_pkg.sv
// shared constants and codes for the periodic tick compare scheduler
package ptcs_pkg;

  localparam int DATA_W           = 64;
  localparam int ADJ_W            = 60;
  localparam int STAT_W           = 32;
  localparam int EVT_W            = 16;
  localparam int EVENT_COUNT_BITS = 16;
  localparam int DIV_STEPS        = DATA_W;
  localparam int DIV_CNT_W        = $clog2(DIV_STEPS);

  localparam logic [DATA_W-1:0] DISABLED_CMP = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [DATA_W-1:0] EVT_LIMIT    =
    (DATA_W'(1) << EVENT_COUNT_BITS) - DATA_W'(1);

  // item commands
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_IRQ   = 1'b1;

  // configuration register indexes
  localparam logic REG_PERIOD      = 1'b0;
  localparam logic REG_FIRST_DELAY = 1'b1;

endpackage

FILE: rtl/ptcs_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ptcs_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [ptcs_pkg::DATA_W-1:0]   dividend,
  input  logic [ptcs_pkg::DATA_W-1:0]   divisor,
  output logic                          done,
  output logic [ptcs_pkg::DATA_W-1:0]   quotient,
  output logic [ptcs_pkg::DATA_W-1:0]   remainder
);

  logic                            busy_r;
  logic                            done_r;
  logic [ptcs_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic [ptcs_pkg::DATA_W-1:0]     quo_r;
  logic [ptcs_pkg::DATA_W-1:0]     rem_r;
  logic [ptcs_pkg::DATA_W-1:0]     dvs_r;
  logic [ptcs_pkg::DATA_W:0]       shifted;
  logic [ptcs_pkg::DATA_W:0]       diff;
  logic                            qbit;

  // shift the next dividend bit into the partial remainder and try a subtract
  assign shifted = {rem_r, quo_r[ptcs_pkg::DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign qbit    = ~diff[ptcs_pkg::DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ptcs_pkg::DIV_CNT_W'(ptcs_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ptcs_pkg::DIV_CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ptcs_pkg::DATA_W-2:0], qbit};
      rem_r <= qbit ? diff[ptcs_pkg::DATA_W-1:0] : shifted[ptcs_pkg::DATA_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: rtl/periodic_tick_compare_scheduler_unit.sv
// Periodic tick scheduler over a free-running 64-bit counter. One item is in
// work at a time. An item that needs a division by the period (a start with a
// nonzero period, or an interrupt with a nonzero period whose counter is not
// before the reference) goes through the bit-serial divider, which produces
// one quotient bit per cycle; then S_ALIGN picks up quotient and remainder
// and aligns, and S_FIN retires the item once the output register is free or
// being read. Any other item skips the divider and goes to S_ALIGN. A new item is accepted as
// soon as the previous one has retired, even while its result still waits in
// the output register. Configuration writes are taken at any time but belong
// between items.
module periodic_tick_compare_scheduler_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [ptcs_pkg::DATA_W-1:0]        cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [ptcs_pkg::DATA_W-1:0]        in_counter,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ptcs_pkg::DATA_W-1:0]        out_next_compare,
  output logic [ptcs_pkg::EVT_W-1:0]         out_event_count,
  output logic                               out_count_saturated,
  output logic                               out_adjust_active,
  output logic [ptcs_pkg::STAT_W-1:0]        out_edges_total,
  output logic [ptcs_pkg::STAT_W-1:0]        out_excess_total,
  output logic [ptcs_pkg::STAT_W-1:0]        out_missed_total,
  output logic [ptcs_pkg::STAT_W-1:0]        out_adjusted_total
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_ALIGN,
    S_FIN
  } state_t;

  state_t                         state_r;
  logic [ptcs_pkg::DATA_W-1:0]    period_r;
  logic [ptcs_pkg::DATA_W-1:0]    first_delay_r;
  logic [ptcs_pkg::DATA_W-1:0]    reference_r;
  logic [ptcs_pkg::ADJ_W-1:0]     adjustment_r;
  logic [ptcs_pkg::STAT_W-1:0]    edges_r;
  logic [ptcs_pkg::STAT_W-1:0]    excess_r;
  logic [ptcs_pkg::STAT_W-1:0]    missed_r;
  logic [ptcs_pkg::STAT_W-1:0]    adjusted_r;

  logic                           cmd_r;
  logic                           before_r;
  logic [ptcs_pkg::DATA_W-1:0]    ctr_r;
  logic [ptcs_pkg::DATA_W-1:0]    delta_r;
  logic [ptcs_pkg::DATA_W-1:0]    base_r;
  logic [ptcs_pkg::DATA_W-1:0]    cmp_r;
  logic [ptcs_pkg::DATA_W-1:0]    count_r;
  logic [ptcs_pkg::DATA_W-1:0]    rem_r;

  logic                           out_valid_r;
  logic [ptcs_pkg::DATA_W-1:0]    out_cmp_r;
  logic [ptcs_pkg::EVT_W-1:0]     out_evt_r;
  logic                           out_sat_r;
  logic                           out_adj_r;

  logic                           accept;
  logic [ptcs_pkg::DATA_W-1:0]    delta_in;
  logic                           before_in;
  logic                           period_zero;
  logic                           need_div;
  logic                           div_done;
  logic [ptcs_pkg::DATA_W-1:0]    div_quo;
  logic [ptcs_pkg::DATA_W-1:0]    div_rem;
  logic [ptcs_pkg::DATA_W-1:0]    count_sel;
  logic [ptcs_pkg::DATA_W-1:0]    rem_sel;
  logic                           retire;
  logic                           late;
  logic                           sat;
  logic [ptcs_pkg::ADJ_W-1:0]     adjustment_nxt;

  assign in_ready    = (state_r == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign period_zero = (period_r == '0);
  assign delta_in    = in_counter - reference_r;
  assign before_in   = delta_in[ptcs_pkg::DATA_W-1];
  assign need_div    = !period_zero && !((in_cmd == ptcs_pkg::CMD_IRQ) && before_in);

  ptcs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (accept && need_div),
    .dividend  ((in_cmd == ptcs_pkg::CMD_IRQ) ? delta_in : in_counter),
    .divisor   (period_r),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // elapsed periods and leftover for an interrupt item
  always_comb begin
    if (before_r) begin
      count_sel = '0;
      rem_sel   = '0;
    end else if (period_zero) begin
      count_sel = ptcs_pkg::DATA_W'(1);
      rem_sel   = delta_r;
    end else begin
      count_sel = div_quo;
      rem_sel   = div_rem;
    end
  end

  assign retire = (state_r == S_FIN) && (!out_valid_r || out_ready);
  assign late   = (rem_r > (period_r >> 3));
  assign sat    = (count_r > ptcs_pkg::EVT_LIMIT);

  always_comb begin
    if ((count_r != '0) && late) begin
      adjustment_nxt = period_r[ptcs_pkg::DATA_W-1:4];
    end else begin
      adjustment_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r      <= '0;
      first_delay_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ptcs_pkg::REG_PERIOD:      period_r      <= cfg_wdata;
        ptcs_pkg::REG_FIRST_DELAY: first_delay_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      reference_r  <= '0;
      adjustment_r <= '0;
      edges_r      <= '0;
      excess_r     <= '0;
      missed_r     <= '0;
      adjusted_r   <= '0;
    end else begin
      if (retire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            cmd_r    <= in_cmd;
            ctr_r    <= in_counter;
            delta_r  <= delta_in;
            before_r <= before_in;
            state_r  <= need_div ? S_DIV : S_ALIGN;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_ALIGN;
          end
        end
        S_ALIGN: begin
          if (cmd_r == ptcs_pkg::CMD_START) begin
            // round up to the next multiple of the period, wrapping
            if (period_zero || (div_rem == '0)) begin
              base_r <= ctr_r;
            end else begin
              base_r <= ctr_r + period_r - div_rem;
            end
            count_r <= '0;
            rem_r   <= '0;
          end else begin
            base_r  <= before_r ? reference_r : (ctr_r - rem_sel);
            count_r <= count_sel;
            rem_r   <= rem_sel;
          end
          cmp_r   <= period_zero ? ptcs_pkg::DISABLED_CMP
                                 : (ctr_r + period_r - {4'b0, adjustment_r});
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (retire) begin
            out_evt_r   <= sat ? ptcs_pkg::EVT_LIMIT[ptcs_pkg::EVT_W-1:0]
                               : count_r[ptcs_pkg::EVT_W-1:0];
            out_sat_r   <= sat;
            reference_r <= base_r;
            if (cmd_r == ptcs_pkg::CMD_START) begin
              out_cmp_r    <= base_r + first_delay_r;
              out_adj_r    <= 1'b0;
              adjustment_r <= '0;
            end else begin
              out_cmp_r    <= cmp_r;
              out_adj_r    <= (adjustment_nxt != '0);
              adjustment_r <= adjustment_nxt;
              if (adjustment_r != '0) begin
                adjusted_r <= adjusted_r + count_r[ptcs_pkg::STAT_W-1:0];
              end
              if (count_r != '0) begin
                missed_r <= missed_r + count_r[ptcs_pkg::STAT_W-1:0]
                            - ptcs_pkg::STAT_W'(1);
                if (late && (adjustment_r == '0)) begin
                  edges_r <= edges_r + ptcs_pkg::STAT_W'(1);
                end
              end else begin
                excess_r <= excess_r + ptcs_pkg::STAT_W'(1);
              end
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_compare    = out_cmp_r;
  assign out_event_count     = out_evt_r;
  assign out_count_saturated = out_sat_r;
  assign out_adjust_active   = out_adj_r;
  assign out_edges_total     = edges_r;
  assign out_excess_total    = excess_r;
  assign out_missed_total    = missed_r;
  assign out_adjusted_total  = adjusted_r;

endmodule

FILE: rtl/ptcs_checker.sv
// port-level checks for the periodic tick compare scheduler
module ptcs_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [ptcs_pkg::DATA_W-1:0]        out_next_compare,
  input logic [ptcs_pkg::EVT_W-1:0]         out_event_count,
  input logic                               out_count_saturated,
  input logic                               out_adjust_active
);

  // a waiting result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_compare))
    else $error("stalled result changed");

  // one item in work at a time
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

  // saturation shows the clamped count
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_count_saturated |->
      out_event_count == ptcs_pkg::EVT_LIMIT[ptcs_pkg::EVT_W-1:0])
    else $error("saturated count not clamped");

  // an adjustment is only armed by an interrupt that fired events
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_adjust_active |-> out_event_count != '0)
    else $error("adjustment active with no events");

  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind periodic_tick_compare_scheduler_unit ptcs_checker u_ptcs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_next_compare    (out_next_compare),
  .out_event_count     (out_event_count),
  .out_count_saturated (out_count_saturated),
  .out_adjust_active   (out_adjust_active)
);
